@@ design/scsa_pkg.sv @@
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared widths, status codes, class size table and the class pick record
// for the size class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scsa_pkg;

    // fixed field widths
    localparam int SIZE_W  = 20;
    localparam int CLS_W   = 4;
    localparam int SLOT_W  = 6;
    localparam int BYTES_W = 10;
    localparam int STAT_W  = 3;

    // class pool defaults and limit
    localparam int MAX_CLASSES       = 10;
    localparam int DEF_CLASS_COUNT   = 10;
    localparam int DEF_SLOTS_PER_CLS = 64;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO        = 3'd1;
    localparam logic [STAT_W-1:0] ST_BIG         = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_HANDLE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 3'd5;

    // outcome of the size to class decode
    typedef struct packed {
        logic             zero;
        logic             big;
        logic [CLS_W-1:0] cls;
    } t_pick;

    // usable bytes of each size class
    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] idx);
        logic [BYTES_W-1:0] b;
        unique case (idx)
            4'd0:    b = 10'd16;
            4'd1:    b = 10'd32;
            4'd2:    b = 10'd48;
            4'd3:    b = 10'd64;
            4'd4:    b = 10'd96;
            4'd5:    b = 10'd128;
            4'd6:    b = 10'd192;
            4'd7:    b = 10'd256;
            4'd8:    b = 10'd384;
            4'd9:    b = 10'd512;
            default: b = 10'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ design/size_class_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// Segregated free list slot allocator: allocate pops a slot from the LIFO
// stack of the chosen size class, free checks the handle and pushes it back.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser opcode, tdata request
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser status, tdata grant
//
//  One request per cycle while m_axis_tready keeps results moving, one result
//  each: the free stack and busy memories are read at accept, and the stage
//  after them commits the pop or push while writing the result register.
//  Reset needs no clearing pass: a per class low water mark tells untouched
//  stack entries (reading their own index) and never granted slots.
//  A result held by m_axis_tready low holds the next request in its stage.
//
`default_nettype none

module size_class_slot_allocator #(
    parameter int CLASS_COUNT     = scsa_pkg::DEF_CLASS_COUNT,
    parameter int SLOTS_PER_CLASS = scsa_pkg::DEF_SLOTS_PER_CLS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] opcode
    input  wire logic        s_axis_tuser,
    // [19:0] req_size, [23:20] free_class, [29:24] free_slot, [31:30] zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status
    output logic [2:0]       m_axis_tuser,
    // [3:0] grant_class, [9:4] grant_slot, [19:10] grant_bytes, [23:20] zero
    output logic [23:0]      m_axis_tdata
);
    import scsa_pkg::*;

    localparam int IW    = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int DW    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int CW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // flat memory address of an entry of a class
    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] c,
                                             input logic [IW-1:0] i);
        return AW'(c) * AW'(SLOTS_PER_CLASS) + AW'(i);
    endfunction

    // request fields
    logic              in_op;
    logic [SIZE_W-1:0] in_size;
    logic [CLS_W-1:0]  in_fcls;
    logic [SLOT_W-1:0] in_fslot;
    t_pick             in_pick;
    logic              in_bad;
    logic [CW-1:0]     in_cls;
    logic [IW-1:0]     in_fidx;
    logic [DW-1:0]     in_depth;
    logic              in_acc;

    assign in_op    = s_axis_tuser;
    assign in_size  = s_axis_tdata[19:0];
    assign in_fcls  = s_axis_tdata[23:20];
    assign in_fslot = s_axis_tdata[29:24];

    scsa_class_pick #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_pick (
        .i_size (in_size),
        .o_pick (in_pick)
    );

    // per class state
    logic [DW-1:0] r_depth [CLASS_COUNT];
    logic [DW-1:0] r_lw    [CLASS_COUNT];

    // memories
    logic [IW-1:0] r_stack [DEPTH];
    logic          r_busy  [DEPTH];
    logic [IW-1:0] r_stk_q;
    logic          r_busy_q;

    // request stage
    logic          r_s1_valid;
    logic          r_s1_op;
    logic          r_s1_zero;
    logic          r_s1_big;
    logic          r_s1_bad;
    logic [CW-1:0] r_s1_cls;
    logic [IW-1:0] r_s1_fidx;

    // result register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_user;
    logic [23:0]       r_out_data;

    // stage outcome
    logic              s1_adv;
    logic [DW-1:0]     s1_depth;
    logic [DW-1:0]     s1_lw;
    logic [DW-1:0]     s1_top;
    logic [IW-1:0]     s1_slot;
    logic              s1_busy;
    logic [STAT_W-1:0] n_status;
    logic [23:0]       n_data;
    logic              upd_en;
    logic [DW-1:0]     upd_depth;
    logic [DW-1:0]     upd_lw;
    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    logic [IW-1:0]     stk_wdata;
    logic              busy_we;
    logic [AW-1:0]     busy_waddr;
    logic              busy_wdata;
    logic [AW-1:0]     stk_raddr;
    logic [AW-1:0]     busy_raddr;

    // handshake
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // stage logic: pop or push against the committed class state
    assign s1_depth = r_depth[r_s1_cls];
    assign s1_lw    = r_lw[r_s1_cls];
    assign s1_top   = s1_depth - DW'(1);
    assign s1_slot  = (s1_top < s1_lw) ? IW'(s1_top) : r_stk_q;
    assign s1_busy  = (DW'(r_s1_fidx) >= s1_lw) ? r_busy_q : 1'b0;

    always_comb begin
        n_status   = ST_OK;
        n_data     = '0;
        upd_en     = 1'b0;
        upd_depth  = s1_depth;
        upd_lw     = s1_lw;
        stk_we     = 1'b0;
        stk_waddr  = f_addr(r_s1_cls, IW'(s1_depth));
        stk_wdata  = r_s1_fidx;
        busy_we    = 1'b0;
        busy_waddr = f_addr(r_s1_cls, s1_slot);
        busy_wdata = 1'b1;
        if (r_s1_op == OP_ALLOC) begin
            priority if (r_s1_zero) begin
                n_status = ST_ZERO;
            end else if (r_s1_big) begin
                n_status = ST_BIG;
            end else if (s1_depth == '0) begin
                n_status = ST_EXHAUSTED;
            end else begin
                upd_en    = 1'b1;
                upd_depth = s1_top;
                upd_lw    = (s1_top < s1_lw) ? s1_top : s1_lw;
                busy_we   = 1'b1;
                n_data    = {4'd0, class_bytes(CLS_W'(r_s1_cls)),
                             SLOT_W'(s1_slot), CLS_W'(r_s1_cls)};
            end
        end else begin
            busy_waddr = f_addr(r_s1_cls, r_s1_fidx);
            busy_wdata = 1'b0;
            priority if (r_s1_bad) begin
                n_status = ST_BAD_HANDLE;
            end else if (!s1_busy) begin
                n_status = ST_DOUBLE_FREE;
            end else begin
                busy_we = 1'b1;
                if (s1_depth < DW'(SLOTS_PER_CLASS)) begin
                    upd_en    = 1'b1;
                    upd_depth = s1_depth + DW'(1);
                    stk_we    = 1'b1;
                end
            end
        end
    end

    // incoming request: class, handle check, forwarded depth, read addresses
    assign in_bad   = (32'(in_fcls) >= CLASS_COUNT) || (32'(in_fslot) >= SLOTS_PER_CLASS);
    assign in_fidx  = in_bad ? '0 : IW'(in_fslot);
    always_comb begin
        if (in_op == OP_ALLOC) begin
            in_cls = CW'(in_pick.cls);
        end else begin
            in_cls = in_bad ? '0 : CW'(in_fcls);
        end
    end
    assign in_depth   = (s1_adv && upd_en && (r_s1_cls == in_cls)) ? upd_depth
                                                                   : r_depth[in_cls];
    assign stk_raddr  = f_addr(in_cls, IW'(in_depth - DW'(1)));
    assign busy_raddr = f_addr(in_cls, in_fidx);

    // free stack memory with write to read bypass
    always_ff @(posedge i_clk) begin
        if (s1_adv && stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        if (in_acc) begin
            if (s1_adv && stk_we && (stk_waddr == stk_raddr)) begin
                r_stk_q <= stk_wdata;
            end else begin
                r_stk_q <= r_stack[stk_raddr];
            end
        end
    end

    // busy mark memory with write to read bypass
    always_ff @(posedge i_clk) begin
        if (s1_adv && busy_we) begin
            r_busy[busy_waddr] <= busy_wdata;
        end
        if (in_acc) begin
            if (s1_adv && busy_we && (busy_waddr == busy_raddr)) begin
                r_busy_q <= busy_wdata;
            end else begin
                r_busy_q <= r_busy[busy_raddr];
            end
        end
    end

    // class depth and low water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_depth[c] <= DW'(SLOTS_PER_CLASS);
                r_lw[c]    <= DW'(SLOTS_PER_CLASS);
            end
        end else if (s1_adv && upd_en) begin
            r_depth[r_s1_cls] <= upd_depth;
            r_lw[r_s1_cls]    <= upd_lw;
        end
    end

    // request stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op   <= in_op;
            r_s1_zero <= in_pick.zero;
            r_s1_big  <= in_pick.big;
            r_s1_bad  <= in_bad;
            r_s1_cls  <= in_cls;
            r_s1_fidx <= in_fidx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_user <= n_status;
            r_out_data <= n_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_user != ST_OK) |-> (r_out_data == '0))
        else $error("failed request carries grant fields");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (s1_depth <= DW'(SLOTS_PER_CLASS)))
        else $error("class depth beyond pool size");

    a_lw_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (s1_lw <= s1_depth))
        else $error("low water mark above class depth");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_cls) && $stable(r_stk_q))
        else $error("stalled request stage changed");

endmodule

`default_nettype wire

@@ design/scsa_class_pick.sv @@
// ----------------------------------------------------------------------------
// scsa_class_pick
// Maps a requested byte count to the first size class that holds it once
// rounded up to 16 bytes; flags a zero size and a size above the last class.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_class_pick #(
    parameter int CLASS_COUNT = scsa_pkg::DEF_CLASS_COUNT
) (
    input  wire logic [scsa_pkg::SIZE_W-1:0] i_size,
    output scsa_pkg::t_pick                  o_pick
);
    import scsa_pkg::*;

    logic             found;
    logic [CLS_W-1:0] cls;

    // class sizes are multiples of 16, so comparing the raw size is the
    // same as comparing the rounded size; scan downward so the first wins
    always_comb begin
        found = 1'b0;
        cls   = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (i_size <= SIZE_W'(class_bytes(CLS_W'(c)))) begin
                found = 1'b1;
                cls   = CLS_W'(c);
            end
        end
    end

    assign o_pick.zero = (i_size == '0);
    assign o_pick.big  = !found;
    assign o_pick.cls  = found ? cls : '0;

endmodule

`default_nettype wire
